/* hw/rtl/dtq_pkg.sv */
// ----------------------------------------------------------------------------
// dtq_pkg
// Types, codes and constants shared by the deadline timer queue files.
// ----------------------------------------------------------------------------
package dtq_pkg;

    localparam int TIME_W      = 63;
    localparam int HANDLE_W    = 16;
    localparam int MAX_RESULTS = 64;
    localparam int RES_W       = $clog2(MAX_RESULTS);

    localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

    localparam logic OP_ADD  = 1'b0;
    localparam logic OP_TICK = 1'b1;

    typedef enum logic [1:0] {
        KIND_ACCEPTED = 2'd0,
        KIND_DROPPED  = 2'd1,
        KIND_EXPIRED  = 2'd2,
        KIND_NONE     = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        RD_MIN,
        RD_NEXT,
        RD_PTR
    } rd_sel_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ADD,
        S_TICK,
        S_RM_RD,
        S_RM_CAP,
        S_SH_CHK,
        S_SH_RD,
        S_SH_WR,
        S_SC_CHK,
        S_SC_CMP,
        S_EMIT
    } state_t;

    typedef struct packed {
        logic [HANDLE_W-1:0] handle;
        logic [TIME_W-1:0]   deadline;
    } entry_t;

    typedef struct packed {
        logic    latch_in;
        logic    add_commit;
        logic    load_out;
        kind_t   out_kind;
        logic    mem_rd;
        rd_sel_t rd_sel;
        logic    mem_wr_shift;
        logic    cap_victim;
        logic    ptr_inc;
        logic    dec_count;
        logic    scan_reset;
        logic    scan_cmp;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic due;
        logic shift_more;
        logic scan_more;
        logic out_free;
        logic emit_last;
    } status_t;

endpackage

/* hw/rtl/dtq_if.sv */
// ----------------------------------------------------------------------------
// dtq_if
// Valid/ready channels for the input items and the result words.
// ----------------------------------------------------------------------------
interface dtq_item_if;
    import dtq_pkg::*;

    logic                valid;
    logic                ready;
    logic                operation;
    logic [HANDLE_W-1:0] timer_handle;
    logic [TIME_W-1:0]   delay;
    logic [TIME_W-1:0]   now;

    modport source (output valid, output operation, output timer_handle,
                    output delay, output now, input ready);
    modport sink   (input valid, input operation, input timer_handle,
                    input delay, input now, output ready);
endinterface

interface dtq_result_if;
    import dtq_pkg::*;

    logic                valid;
    logic                ready;
    logic [1:0]          kind;
    logic [HANDLE_W-1:0] timer_handle_out;
    logic [TIME_W-1:0]   deadline_out;
    logic [TIME_W-1:0]   next_deadline;
    logic                last;

    modport source (output valid, output kind, output timer_handle_out,
                    output deadline_out, output next_deadline, output last,
                    input ready);
    modport sink   (input valid, input kind, input timer_handle_out,
                    input deadline_out, input next_deadline, input last,
                    output ready);
endinterface

/* hw/rtl/dtq_ctrl.sv */
// ----------------------------------------------------------------------------
// dtq_ctrl
// Sequencer for add, tick, removal shift and minimum rescan.
// ----------------------------------------------------------------------------
module dtq_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              in_op,
    output logic              in_ready,
    input  dtq_pkg::status_t  status,
    output dtq_pkg::cmd_t     cmd
);
    import dtq_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.out_kind = KIND_NONE;
        cmd.rd_sel   = RD_PTR;
        in_ready   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.latch_in = 1'b1;
                    state_next   = (in_op == OP_ADD) ? S_ADD : S_TICK;
                end
            end
            S_ADD:
            begin
                if (status.out_free)
                begin
                    cmd.load_out   = 1'b1;
                    cmd.out_kind   = status.full ? KIND_DROPPED : KIND_ACCEPTED;
                    cmd.add_commit = !status.full;
                    state_next     = S_IDLE;
                end
            end
            S_TICK:
            begin
                if (status.due)
                begin
                    state_next = S_RM_RD;
                end
                else if (status.out_free)
                begin
                    cmd.load_out = 1'b1;
                    cmd.out_kind = KIND_NONE;
                    state_next   = S_IDLE;
                end
            end
            S_RM_RD:
            begin
                cmd.mem_rd = 1'b1;
                cmd.rd_sel = RD_MIN;
                state_next = S_RM_CAP;
            end
            S_RM_CAP:
            begin
                cmd.cap_victim = 1'b1;
                state_next     = S_SH_CHK;
            end
            S_SH_CHK:
            begin
                if (status.shift_more)
                begin
                    state_next = S_SH_RD;
                end
                else
                begin
                    cmd.dec_count  = 1'b1;
                    cmd.scan_reset = 1'b1;
                    state_next     = S_SC_CHK;
                end
            end
            S_SH_RD:
            begin
                cmd.mem_rd = 1'b1;
                cmd.rd_sel = RD_NEXT;
                state_next = S_SH_WR;
            end
            S_SH_WR:
            begin
                cmd.mem_wr_shift = 1'b1;
                cmd.ptr_inc      = 1'b1;
                state_next       = S_SH_CHK;
            end
            S_SC_CHK:
            begin
                if (status.scan_more)
                begin
                    cmd.mem_rd = 1'b1;
                    cmd.rd_sel = RD_PTR;
                    state_next = S_SC_CMP;
                end
                else
                begin
                    state_next = S_EMIT;
                end
            end
            S_SC_CMP:
            begin
                cmd.scan_cmp = 1'b1;
                cmd.ptr_inc  = 1'b1;
                state_next   = S_SC_CHK;
            end
            S_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.load_out = 1'b1;
                    cmd.out_kind = KIND_EXPIRED;
                    state_next   = status.emit_last ? S_IDLE : S_RM_RD;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

/* hw/rtl/dtq_datapath.sv */
// ----------------------------------------------------------------------------
// dtq_datapath
// Timer store, earliest-deadline tracking and the result register.
// ----------------------------------------------------------------------------
module dtq_datapath #(
    parameter int SLOTS = 64
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [dtq_pkg::HANDLE_W-1:0]  in_timer_handle,
    input  logic [dtq_pkg::TIME_W-1:0]    in_delay,
    input  logic [dtq_pkg::TIME_W-1:0]    in_now,
    input  dtq_pkg::cmd_t                 cmd,
    output dtq_pkg::status_t              status,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [1:0]                    out_kind,
    output logic [dtq_pkg::HANDLE_W-1:0]  out_handle,
    output logic [dtq_pkg::TIME_W-1:0]    out_deadline,
    output logic [dtq_pkg::TIME_W-1:0]    out_next,
    output logic                          out_last
);
    import dtq_pkg::*;

    localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CW = $clog2(SLOTS + 1);

    entry_t mem [SLOTS];
    entry_t rdata_reg;

    logic [HANDLE_W-1:0] handle_reg;
    logic [TIME_W-1:0]   delay_reg;
    logic [TIME_W-1:0]   now_reg;

    logic [CW-1:0]       count_reg;
    logic [CW-1:0]       ptr_reg;
    logic [TIME_W-1:0]   min_reg;
    logic [IW-1:0]       min_idx_reg;
    logic [RES_W-1:0]    res_n_reg;
    logic [HANDLE_W-1:0] vic_handle_reg;
    logic [TIME_W-1:0]   vic_deadline_reg;

    logic                out_valid_reg;
    logic [1:0]          out_kind_reg;
    logic [HANDLE_W-1:0] out_handle_reg;
    logic [TIME_W-1:0]   out_deadline_reg;
    logic [TIME_W-1:0]   out_next_reg;
    logic                out_last_reg;

    logic [TIME_W:0]     sum;
    logic [TIME_W-1:0]   add_deadline;
    logic                add_is_min;
    logic [TIME_W-1:0]   min_after_add;
    logic [CW-1:0]       ptr_plus;
    logic [IW-1:0]       rd_addr;
    logic [IW-1:0]       wr_addr;
    entry_t              wr_data;
    logic                wr_en;

    function automatic logic [1:0] out_kind_code(kind_t k);
        return k;
    endfunction

    // saturate the deadline at the maximum time
    assign sum           = {1'b0, now_reg} + {1'b0, delay_reg};
    assign add_deadline  = sum[TIME_W] ? TIME_MAX : sum[TIME_W-1:0];
    assign add_is_min    = (count_reg == '0) || (add_deadline < min_reg);
    assign min_after_add = add_is_min ? add_deadline : min_reg;
    assign ptr_plus      = ptr_reg + 1'b1;

    assign status.full       = (count_reg == CW'(SLOTS));
    assign status.due        = (count_reg != '0) && (min_reg <= now_reg);
    assign status.shift_more = (ptr_plus < count_reg);
    assign status.scan_more  = (ptr_reg < count_reg);
    assign status.out_free   = !out_valid_reg || out_ready;
    assign status.emit_last  = (count_reg == '0) || (min_reg > now_reg)
                               || (res_n_reg == RES_W'(MAX_RESULTS - 1));

    always_comb
    begin
        case (cmd.rd_sel)
            RD_MIN:  rd_addr = min_idx_reg;
            RD_NEXT: rd_addr = ptr_plus[IW-1:0];
            default: rd_addr = ptr_reg[IW-1:0];
        endcase
    end

    assign wr_en   = cmd.add_commit || cmd.mem_wr_shift;
    assign wr_addr = cmd.add_commit ? count_reg[IW-1:0] : ptr_reg[IW-1:0];
    assign wr_data = cmd.add_commit ? entry_t'{handle: handle_reg, deadline: add_deadline}
                                    : rdata_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (cmd.mem_rd)
        begin
            rdata_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch_in)
        begin
            handle_reg <= in_timer_handle;
            delay_reg  <= in_delay;
            now_reg    <= in_now;
        end
        if (cmd.cap_victim)
        begin
            vic_handle_reg   <= rdata_reg.handle;
            vic_deadline_reg <= min_reg;
        end
        if (cmd.load_out)
        begin
            out_kind_reg <= out_kind_code(cmd.out_kind);
            unique case (cmd.out_kind)
                KIND_ACCEPTED:
                begin
                    out_handle_reg   <= handle_reg;
                    out_deadline_reg <= add_deadline;
                    out_next_reg     <= min_after_add;
                    out_last_reg     <= 1'b1;
                end
                KIND_EXPIRED:
                begin
                    out_handle_reg   <= vic_handle_reg;
                    out_deadline_reg <= vic_deadline_reg;
                    out_next_reg     <= min_reg;
                    out_last_reg     <= status.emit_last;
                end
                default:
                begin
                    out_handle_reg   <= '0;
                    out_deadline_reg <= '0;
                    out_next_reg     <= min_reg;
                    out_last_reg     <= 1'b1;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            ptr_reg       <= '0;
            min_reg       <= TIME_MAX;
            min_idx_reg   <= '0;
            res_n_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.latch_in)
            begin
                res_n_reg <= '0;
            end
            else if (cmd.load_out && (cmd.out_kind == KIND_EXPIRED))
            begin
                res_n_reg <= res_n_reg + 1'b1;
            end

            if (cmd.add_commit)
            begin
                count_reg <= count_reg + 1'b1;
                if (add_is_min)
                begin
                    min_reg     <= add_deadline;
                    min_idx_reg <= count_reg[IW-1:0];
                end
            end
            else if (cmd.dec_count)
            begin
                count_reg <= count_reg - 1'b1;
            end

            // start the shift at the removed slot, the rescan at slot zero
            if (cmd.cap_victim)
            begin
                ptr_reg <= CW'(min_idx_reg);
            end
            else if (cmd.scan_reset)
            begin
                ptr_reg <= '0;
            end
            else if (cmd.ptr_inc)
            begin
                ptr_reg <= ptr_plus;
            end

            if (cmd.scan_reset)
            begin
                min_reg     <= TIME_MAX;
                min_idx_reg <= '0;
            end
            else if (cmd.scan_cmp && (rdata_reg.deadline < min_reg))
            begin
                min_reg     <= rdata_reg.deadline;
                min_idx_reg <= ptr_reg[IW-1:0];
            end

            if (cmd.load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid    = out_valid_reg;
    assign out_kind     = out_kind_reg;
    assign out_handle   = out_handle_reg;
    assign out_deadline = out_deadline_reg;
    assign out_next     = out_next_reg;
    assign out_last     = out_last_reg;

endmodule

/* hw/rtl/deadline_timer_queue.sv */
// ----------------------------------------------------------------------------
// deadline_timer_queue
// Bounded store of pending timers that releases due timers earliest first.
// ----------------------------------------------------------------------------
// Usage:
//   item   : input words, valid/ready. operation 0 adds timer_handle with a
//            deadline of now + delay (saturated at the maximum time);
//            operation 1 is a tick that expires timers due at now, at most 64 per tick.
//   result : output words, valid/ready. One word per add (accepted or
//            dropped when full), one word per expired timer on a tick, or a
//            single nothing-due word. last marks the final word of an item.
//   Every word reports the earliest deadline still pending after it.
// Timing:
//   An add or an idle tick loads its result word in S_ADD or S_TICK after accept,
//   once the result register is free, and the sequencer then returns to idle.
//   A tick that expires timers decides in S_TICK, then per expired timer reads
//   and captures the victim, closes the gap and rescans for the new minimum:
//   the store sits in a single-port-read memory, so closing the gap steps
//   through S_SH_CHK, S_SH_RD and S_SH_WR per entry above the removed slot
//   and the rescan through S_SC_CHK and S_SC_CMP per remaining entry. One item is in work at a time;
//   item.ready is high only while the sequencer is idle.
// Reset clears the timer count and the output valid; no memory sweep is run.
// A stalled receiver holds the result register and the sequencer waits.
// ----------------------------------------------------------------------------
module deadline_timer_queue #(
    parameter int TIMER_SLOTS = 64
) (
    input  logic          clk,
    input  logic          rst_n,
    dtq_item_if.sink      item,
    dtq_result_if.source  result
);
    import dtq_pkg::*;

    cmd_t    cmd;
    status_t status;

    // sequencer: decodes the item and steps through removal and rescan
    dtq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (item.valid),
        .in_op    (item.operation),
        .in_ready (item.ready),
        .status   (status),
        .cmd      (cmd)
    );

    // datapath: timer memory, minimum tracking and the result register
    dtq_datapath #(
        .SLOTS (TIMER_SLOTS)
    ) u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_timer_handle (item.timer_handle),
        .in_delay        (item.delay),
        .in_now          (item.now),
        .cmd             (cmd),
        .status          (status),
        .out_valid       (result.valid),
        .out_ready       (result.ready),
        .out_kind        (result.kind),
        .out_handle      (result.timer_handle_out),
        .out_deadline    (result.deadline_out),
        .out_next        (result.next_deadline),
        .out_last        (result.last)
    );

endmodule

/* bench/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the deadline timer queue: a queue-fed driver pushes
// add and tick words, a scoreboard model predicts every result word, and a
// monitor compares each accepted result word field by field.
// ----------------------------------------------------------------------------
module tb_top;
    import dtq_pkg::*;

    typedef struct {
        logic                operation;
        logic [HANDLE_W-1:0] timer_handle;
        logic [TIME_W-1:0]   delay;
        logic [TIME_W-1:0]   now;
    } item_t;

    typedef struct {
        kind_t               kind;
        logic [HANDLE_W-1:0] handle;
        logic [TIME_W-1:0]   deadline;
        logic [TIME_W-1:0]   next_deadline;
        logic                last;
    } word_t;

    localparam int SLOTS = 64;

    logic clk;
    logic rst_n;

    dtq_item_if   item_ch ();
    dtq_result_if result_ch ();

    deadline_timer_queue #(.TIMER_SLOTS(SLOTS)) dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch.sink),
        .result (result_ch.source)
    );

    // Timer store mirror: live entries packed in insertion order.
    logic [TIME_W-1:0]   timer_deadline [$];
    logic [HANDLE_W-1:0] timer_handle_q [$];

    item_t pending_items [$];
    word_t due_words [$];

    int error_count;
    int send_idle_pct;
    int recv_idle_pct;
    bit recv_hold;
    int hold_cycles;
    bit stim_done;
    bit in_fire;
    logic [TIME_W-1:0] clock_now;

    // Sender and receiver idle percentages per phase.
    int phase_send [3] = '{34, 84, 0};
    int phase_recv [3] = '{84, 34, 0};

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #200000000;
        $display("DONE: errors detected");
        $finish;
    end

    function automatic logic [TIME_W-1:0] earliest_deadline();
        logic [TIME_W-1:0] best;
        best = TIME_MAX;
        foreach (timer_deadline[i])
            if (timer_deadline[i] < best)
                best = timer_deadline[i];
        return best;
    endfunction

    function automatic int earliest_slot();
        int best;
        best = 0;
        for (int i = 1; i < timer_deadline.size(); i++)
            if (timer_deadline[i] < timer_deadline[best])
                best = i;
        return best;
    endfunction

    // Predict the result words of one accepted input word.
    task automatic predict_words(input item_t it);
        logic [TIME_W:0]   sum;
        logic [TIME_W-1:0] dl;
        word_t w;
        int n;
        int idx;
        n = 0;
        if (it.operation == OP_ADD)
        begin
            sum = {1'b0, it.now} + {1'b0, it.delay};
            dl = sum[TIME_W] ? TIME_MAX : sum[TIME_W-1:0];
            if (timer_deadline.size() >= SLOTS)
            begin
                w = '{KIND_DROPPED, '0, '0, earliest_deadline(), 1'b1};
            end
            else
            begin
                timer_deadline.insert(timer_deadline.size(), dl);
                timer_handle_q.insert(timer_handle_q.size(), it.timer_handle);
                w = '{KIND_ACCEPTED, it.timer_handle, dl, earliest_deadline(), 1'b1};
            end
            due_words.insert(due_words.size(), w);
            return;
        end
        while (n < MAX_RESULTS && timer_deadline.size() > 0)
        begin
            idx = earliest_slot();
            if (timer_deadline[idx] > it.now)
                break;
            w.kind = KIND_EXPIRED;
            w.handle = timer_handle_q[idx];
            w.deadline = timer_deadline[idx];
            timer_deadline.delete(idx);
            timer_handle_q.delete(idx);
            w.next_deadline = earliest_deadline();
            w.last = 1'b0;
            due_words.insert(due_words.size(), w);
            n++;
        end
        if (n == 0)
        begin
            w = '{KIND_NONE, '0, '0, earliest_deadline(), 1'b1};
            due_words.insert(due_words.size(), w);
        end
        else
            due_words[$].last = 1'b1;
    endtask

    // Append one item to the pending queue.
    task automatic queue_item(input item_t it);
        pending_items.insert(pending_items.size(), it);
    endtask

    function automatic item_t make_add(logic [HANDLE_W-1:0] h, logic [TIME_W-1:0] d,
                                       logic [TIME_W-1:0] n);
        item_t it;
        it = '{OP_ADD, h, d, n};
        return it;
    endfunction

    function automatic logic [TIME_W-1:0] rand_wide();
        return TIME_W'({$urandom(), $urandom()});
    endfunction

    // Record each input handshake at the rising edge.
    always @(posedge clk)
    begin
        in_fire <= item_ch.valid && item_ch.ready;
    end

    // Driver: present the head of the pending queue at the falling edge.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (in_fire)
            begin
                predict_words(pending_items.pop_front());
            end
            if (pending_items.size() > 0 &&
                (item_ch.valid && !in_fire ||
                 $urandom_range(99) >= send_idle_pct))
            begin
                item_ch.valid        <= 1'b1;
                item_ch.operation    <= pending_items[0].operation;
                item_ch.timer_handle <= pending_items[0].timer_handle;
                item_ch.delay        <= pending_items[0].delay;
                item_ch.now          <= pending_items[0].now;
            end
            else
            begin
                item_ch.valid <= 1'b0;
            end
            // Receiver: a long hold-off overrides the random stall.
            result_ch.ready <= !recv_hold && ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Count down the long receiver hold-off in its own process.
    always @(negedge clk)
    begin
        if (hold_cycles > 0)
        begin
            hold_cycles <= hold_cycles - 1;
            recv_hold <= 1'b1;
        end
        else
        begin
            recv_hold <= 1'b0;
        end
    end

    // Monitor: check each accepted result word against the oldest prediction.
    // A word accepted at this edge was predicted at the preceding falling edge
    // at the latest, since the result is loaded in a later state than the accept.
    always @(posedge clk)
    begin
        word_t w;
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            if (due_words.size() == 0)
            begin
                error_count++;
                if (error_count <= 10)
                    $display("unexpected result word kind=%0d handle=%h",
                             result_ch.kind, result_ch.timer_handle_out);
            end
            else
            begin
                w = due_words.pop_front();
                if (result_ch.kind !== w.kind || result_ch.timer_handle_out !== w.handle ||
                    result_ch.deadline_out !== w.deadline ||
                    result_ch.next_deadline !== w.next_deadline ||
                    result_ch.last !== w.last)
                begin
                    error_count++;
                    if (error_count <= 10)
                        $display({"mismatch exp k=%0d h=%h d=%h n=%h l=%b",
                                  " got k=%0d h=%h d=%h n=%h l=%b"},
                                 w.kind, w.handle, w.deadline, w.next_deadline, w.last,
                                 result_ch.kind, result_ch.timer_handle_out,
                                 result_ch.deadline_out, result_ch.next_deadline,
                                 result_ch.last);
                end
            end
        end
    end

    // Queue one random item: mostly adds near the running clock, with ticks
    // that advance time so that timers come due in bunches.
    task automatic queue_random();
        item_t it;
        int r;
        r = $urandom_range(99);
        it.timer_handle = HANDLE_W'($urandom());
        it.now = clock_now;
        if (r < 55)
        begin
            it.operation = OP_ADD;
            it.delay = TIME_W'($urandom_range(400));
            if ($urandom_range(19) == 0)
                it.delay = rand_wide();
            if ($urandom_range(29) == 0)
                it.now = rand_wide();
        end
        else
        begin
            it.operation = OP_TICK;
            it.delay = rand_wide();
            clock_now = clock_now + TIME_W'($urandom_range(300));
            it.now = clock_now;
            if ($urandom_range(39) == 0)
                it.now = rand_wide();
        end
        queue_item(it);
    endtask

    task automatic drain_all();
        while (pending_items.size() > 0 || item_ch.valid || due_words.size() > 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    initial
    begin
        error_count = 0;
        send_idle_pct = phase_send[0];
        recv_idle_pct = phase_recv[0];
        recv_hold = 1'b0;
        hold_cycles = 0;
        clock_now = 63'd1000;
        rst_n = 1'b0;
        item_ch.valid = 1'b0;
        item_ch.operation = OP_ADD;
        item_ch.timer_handle = '0;
        item_ch.delay = '0;
        item_ch.now = '0;
        result_ch.ready = 1'b0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: tick on empty, field extremes, overflow, ties, full store.
        queue_item('{OP_TICK, 16'hFFFF, TIME_MAX, 63'd0});
        queue_item(make_add(16'h0000, 63'd0, 63'd0));
        queue_item(make_add(16'hFFFF, TIME_MAX, TIME_MAX));
        queue_item(make_add(16'hA5A5, TIME_MAX, 63'd5));
        queue_item(make_add(16'h1111, 63'd10, 63'd100));
        queue_item(make_add(16'h2222, 63'd10, 63'd100));
        queue_item(make_add(16'h3333, 63'd5, 63'd100));
        queue_item('{OP_TICK, 16'h0, 63'd0, 63'd104});
        queue_item('{OP_TICK, 16'h0, 63'd0, 63'd110});
        queue_item('{OP_TICK, 16'h0, 63'd0, TIME_MAX - 63'd1});
        queue_item('{OP_TICK, 16'h0, 63'd0, TIME_MAX});
        // Fill past capacity, then tick twice: the first tick expires a full tick's worth, the second finds none due.
        for (int i = 0; i < SLOTS + 2; i++)
            queue_item(make_add(i[15:0], 63'(i % 3), 63'd50));
        queue_item('{OP_TICK, 16'h0, 63'd0, 63'd60});
        queue_item('{OP_TICK, 16'h0, 63'd0, 63'd60});
        drain_all();

        // Random phases with changing idle mixes.
        for (int p = 0; p < 3; p++)
        begin
            send_idle_pct = phase_send[p];
            recv_idle_pct = phase_recv[p];
            for (int i = 0; i < 100; i++)
                queue_random();
            if (p == 2)
            begin
                // Long receiver hold-off while adds keep coming.
                hold_cycles = 3000;
                for (int i = 0; i < 20; i++)
                    queue_item(make_add(HANDLE_W'($urandom()), 63'd5, clock_now));
            end
            drain_all();
        end

        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule
